>>> sv/hsf_pkg.sv
package hsf_pkg;

    localparam logic [7:0] ChUnderscore = 8'h5F;
    localparam logic [7:0] ChHyphen     = 8'h2D;
    localparam logic [7:0] ChPeriod     = 8'h2E;
    localparam logic [7:0] ChSpace      = 8'h20;
    localparam logic [7:0] ChTab        = 8'h09;
    localparam logic [7:0] ChLf         = 8'h0A;
    localparam logic [7:0] ChCr         = 8'h0D;
    localparam logic [7:0] ChDigit0     = 8'h30;
    localparam logic [7:0] ChDigit9     = 8'h39;
    localparam logic [7:0] ChUpperA     = 8'h41;
    localparam logic [7:0] ChUpperZ     = 8'h5A;
    localparam logic [7:0] ChLowerA     = 8'h61;
    localparam logic [7:0] ChLowerZ     = 8'h7A;
    localparam logic [7:0] CaseBit      = 8'h20;
    localparam logic [7:0] SepReset     = 8'h2D;

    // One queued command: what the back end has to put out for one input byte.
    typedef struct packed {
        logic       two_res;   // separator first, then data
        logic       use_sep;   // the single (or second) result is the separator
        logic       has_byte;  // zero for a bare end marker
        logic [7:0] data;
        logic       last;
    } t_cmd;

endpackage

>>> sv/hsf_front.sv
module hsf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output hsf_pkg::t_cmd o_cmd
);

    logic r_seen, n_seen;
    logic r_pend, n_pend;
    logic r_nons, n_nons;

    logic accept;
    logic upper, lower, letter, passer, space, ws, keep;
    logic pend_upd, nons_upd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        upper  = (i_byte >= hsf_pkg::ChUpperA) && (i_byte <= hsf_pkg::ChUpperZ);
        lower  = (i_byte >= hsf_pkg::ChLowerA) && (i_byte <= hsf_pkg::ChLowerZ);
        letter = upper || lower;
        passer = ((i_byte >= hsf_pkg::ChDigit0) && (i_byte <= hsf_pkg::ChDigit9))
                 || (i_byte == hsf_pkg::ChUnderscore) || (i_byte == hsf_pkg::ChHyphen)
                 || (i_byte == hsf_pkg::ChPeriod);
        space  = (i_byte == hsf_pkg::ChSpace);
        ws     = space || (i_byte == hsf_pkg::ChTab) || (i_byte == hsf_pkg::ChLf)
                 || (i_byte == hsf_pkg::ChCr);
        keep   = letter || (r_seen && passer);
        pend_upd = r_pend || (ws && r_seen);
        nons_upd = r_nons || (ws && r_seen && !space);
    end

    always_comb begin
        o_push = accept && (keep || i_last);
        o_cmd  = '0;
        n_seen = r_seen;
        n_pend = r_pend;
        n_nons = r_nons;
        if (keep) begin
            o_cmd.two_res  = r_seen && r_pend;
            o_cmd.has_byte = 1'b1;
            o_cmd.data     = upper ? (i_byte | hsf_pkg::CaseBit) : i_byte;
            o_cmd.last     = i_last;
            n_seen = 1'b1;
            n_pend = 1'b0;
            n_nons = 1'b0;
        end else begin
            // A trailing run counts only if it holds a tab, LF or CR.
            o_cmd.use_sep  = pend_upd && nons_upd;
            o_cmd.has_byte = pend_upd && nons_upd;
            o_cmd.last     = 1'b1;
            n_pend = pend_upd;
            n_nons = nons_upd;
        end
        if (i_last) begin
            n_seen = 1'b0;
            n_pend = 1'b0;
            n_nons = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_pend <= 1'b0;
            r_nons <= 1'b0;
        end else if (accept) begin
            r_seen <= n_seen;
            r_pend <= n_pend;
            r_nons <= n_nons;
        end
    end

endmodule

>>> sv/hsf_queue.sv
module hsf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsf_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output hsf_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsf_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

endmodule

>>> sv/hsf_back.sv
module hsf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hsf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [7:0]    i_separator,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data,
    output logic          o_has_byte,
    output logic          o_last
);

    logic       r_valid;
    logic       r_phase;
    logic [7:0] r_data;
    logic       r_has;
    logic       r_last;
    logic       load, first_half;

    assign load       = i_cmd_valid && (!r_valid || i_ready);
    assign first_half = i_cmd.two_res && !r_phase;
    assign o_pop      = load && !first_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_phase <= first_half;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_half) begin
                r_data <= i_separator;
                r_has  <= 1'b1;
                r_last <= 1'b0;
            end else begin
                r_data <= i_cmd.use_sep ? i_separator : i_cmd.data;
                r_has  <= i_cmd.has_byte;
                r_last <= i_cmd.last;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_data     = r_data;
    assign o_has_byte = r_has;
    assign o_last     = r_last;

    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_cmd_valid && i_cmd.two_res))
        else $error("second half pending without a two-result command");

    a_phase_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && r_has && !r_last))
        else $error("separator half not shown as a plain byte");

endmodule

>>> sv/heading_slug_filter.sv
// Channel  | Dir | Signals                                  | Carries
// ---------+-----+------------------------------------------+----------------------------
// s_axis   | in  | tvalid, tready, tdata[7:0], tlast        | heading byte, final-byte mark
// m_axis   | out | tvalid, tready, tdata[7:0], tuser, tlast | slug byte, has-byte, end mark
// cfg      | in  | valid, ready, data[7:0]                  | separator byte
//
// Each input byte is classified by the front end, which enqueues at most one command for it,
// so it accepts a byte every cycle while the queue has room.
// The back end puts out one result per cycle from a registered output while the output is
// ready; a byte that follows a whitespace run needs two results, the separator and the byte,
// so it holds the queue head until the second one is loaded. Each command is written into
// the queue and then loaded into the back-end output register, which drives output tvalid.
// Reset (synchronous, active low) clears the slug state, the queue and the output register, and
// sets the separator to a hyphen. Stalls on the output fill the queue and then drop s_axis tready.
module heading_slug_filter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input stream.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    // Output stream.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] has_byte
    output logic       o_m_axis_tlast,
    // Separator register write.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]    r_separator;
    logic          push, full, cmd_valid, pop;
    hsf_pkg::t_cmd push_cmd, head_cmd;

    // The separator register takes a write on any cycle; the user only writes it when idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= hsf_pkg::SepReset;
        end else if (i_cfg_valid) begin
            r_separator <= i_cfg_data;
        end
    end

    // Front end: classifies bytes, tracks the letter and whitespace-run state.
    hsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Command queue decouples the byte intake from output back-pressure.
    hsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // Back end: expands each command into one or two output transfers.
    hsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_separator (r_separator),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_has_byte  (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

>>> dv/testbench.sv
module testbench;

    // Expected slug output, built from each accepted heading byte and drained by the
    // output monitor. The slug state and the separator are kept here so that the
    // expected bytes follow the same rules as the block.
    class slug_scoreboard;
        typedef struct packed {
            logic [7:0] out_byte;
            logic       has_byte;
            logic       out_last;
        } slug_res_t;

        slug_res_t   slug_expected[$];
        logic [7:0]  separator;
        bit          seen_letter;
        bit          run_pending;
        bit          run_has_nonspace;
        int unsigned mismatches;

        function new();
            separator        = hsf_pkg::SepReset;
            seen_letter      = 1'b0;
            run_pending      = 1'b0;
            run_has_nonspace = 1'b0;
            mismatches       = 0;
        endfunction

        function void set_separator(logic [7:0] value);
            separator = value;
        endfunction

        function int pending();
            return slug_expected.size();
        endfunction

        function void push_result(logic [7:0] b, logic has, logic last);
            slug_res_t r;
            r.out_byte = b;
            r.has_byte = has;
            r.out_last = last;
            slug_expected.push_back(r);
        endfunction

        // Slug rules for one heading byte.
        function void note_byte(logic [7:0] c, logic last);
            bit upper;
            bit lower;
            bit passer;
            bit is_space;
            bit ws;
            upper    = (c >= hsf_pkg::ChUpperA) && (c <= hsf_pkg::ChUpperZ);
            lower    = (c >= hsf_pkg::ChLowerA) && (c <= hsf_pkg::ChLowerZ);
            passer   = ((c >= hsf_pkg::ChDigit0) && (c <= hsf_pkg::ChDigit9)) ||
                       (c == hsf_pkg::ChUnderscore) ||
                       (c == hsf_pkg::ChHyphen) || (c == hsf_pkg::ChPeriod);
            is_space = (c == hsf_pkg::ChSpace);
            ws       = is_space || (c == hsf_pkg::ChTab) || (c == hsf_pkg::ChLf) ||
                       (c == hsf_pkg::ChCr);

            if (upper || lower || (seen_letter && passer)) begin
                // A kept byte after a whitespace run is preceded by one separator.
                if (seen_letter && run_pending) begin
                    push_result(separator, 1'b1, 1'b0);
                end
                push_result(upper ? (c | hsf_pkg::CaseBit) : c, 1'b1, last);
                seen_letter      = 1'b1;
                run_pending      = 1'b0;
                run_has_nonspace = 1'b0;
            end else begin
                // Whitespace only counts once the slug has started; other dropped
                // bytes leave a run open.
                if (ws && seen_letter) begin
                    run_pending = 1'b1;
                    if (!is_space) begin
                        run_has_nonspace = 1'b1;
                    end
                end
                if (last) begin
                    // A trailing run survives only if it holds a tab, LF or CR.
                    if (run_pending && run_has_nonspace) begin
                        push_result(separator, 1'b1, 1'b1);
                    end else begin
                        push_result(8'h00, 1'b0, 1'b1);
                    end
                end
            end

            if (last) begin
                seen_letter      = 1'b0;
                run_pending      = 1'b0;
                run_has_nonspace = 1'b0;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t: slug mismatch: %s", $realtime, what);
        endtask

        task check_result(logic [7:0] b, logic has, logic last);
            slug_res_t exp_res;
            if (slug_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte=%02h has=%0b last=%0b",
                                          b, has, last));
            end else begin
                exp_res = slug_expected.pop_front();
                if (b !== exp_res.out_byte) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              b, exp_res.out_byte));
                end
                if (has !== exp_res.has_byte) begin
                    report_mismatch($sformatf("has_byte %0b, expected %0b",
                                              has, exp_res.has_byte));
                end
                if (last !== exp_res.out_last) begin
                    report_mismatch($sformatf("out_last %0b, expected %0b",
                                              last, exp_res.out_last));
                end
            end
        endtask
    endclass

    localparam int unsigned QuietLimit  = 2000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned RandomBytes = 1850;
    localparam int unsigned NumPhases   = 7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tuser;
    logic       o_m_axis_tlast;
    logic       o_cfg_ready;

    slug_scoreboard slug_sb;
    int unsigned    burst_left = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    ready_cycle = 0;
    int unsigned    ready_mode = 0;

    heading_slug_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),   // [7:0] in_byte
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] out_byte
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] has_byte
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: every transfer is checked against the oldest expected result. The
    // ready pattern switches at random between always ready, coin flips and two
    // periodic stall shapes, so stalls land on every phase of the output sequence.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            slug_sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
        ready_cycle <= ready_cycle + 1;
        if ((ready_cycle % 64) == 0) begin
            ready_mode <= $urandom_range(0, 3);
        end
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (ready_cycle % 5) != 0;
            end
            default: begin
                m_ready <= (ready_cycle % 8) < 3;
            end
        endcase
    end

    // The watchdog ends a hung run: it counts cycles in which no transfer happens on
    // any channel. The longest legal quiet stretch is a sender gap or a drain wait.
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one heading byte. The sender works in bursts; between bursts tvalid drops
    // for a random gap. Some bursts are long, giving stretches with no idling at all.
    task automatic push_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        slug_sb.note_byte(b, last);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            push_byte(text[i], i == text.len() - 1);
        end
    endtask

    // Waits for every expected result, then lets the pipeline settle, since a dropped
    // byte may still be in flight with no result to wait for.
    task automatic drain_slug();
        s_valid <= 1'b0;
        while (slug_sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        slug_sb.set_separator(value);
        cfg_valid <= 1'b0;
    endtask

    // Byte mix for headings: mostly letters, with digits, passers, whitespace of all
    // four kinds, printable punctuation, control bytes and non-ASCII bytes.
    function automatic logic [7:0] pick_heading_byte();
        int unsigned roll;
        logic [7:0]  passers[3];
        logic [7:0]  breaks[3];
        passers = '{hsf_pkg::ChUnderscore, hsf_pkg::ChHyphen, hsf_pkg::ChPeriod};
        breaks  = '{hsf_pkg::ChTab, hsf_pkg::ChLf, hsf_pkg::ChCr};
        roll = $urandom_range(0, 99);
        if (roll < 22) begin
            return hsf_pkg::ChUpperA + 8'($urandom_range(0, 25));
        end else if (roll < 45) begin
            return hsf_pkg::ChLowerA + 8'($urandom_range(0, 25));
        end else if (roll < 55) begin
            return hsf_pkg::ChDigit0 + 8'($urandom_range(0, 9));
        end else if (roll < 62) begin
            return passers[$urandom_range(0, 2)];
        end else if (roll < 72) begin
            return hsf_pkg::ChSpace;
        end else if (roll < 80) begin
            return breaks[$urandom_range(0, 2)];
        end else if (roll < 88) begin
            return 8'($urandom_range(32, 126));
        end else if (roll < 94) begin
            return 8'($urandom_range(0, 31));
        end
        return 8'($urandom_range(128, 255));
    endfunction

    // One random heading. Most are drawn from the heading mix; some end on a forced
    // whitespace tail, and a few are pure noise over the whole byte range.
    task automatic push_random_heading();
        int unsigned len;
        bit          noisy;
        bit          ws_tail;
        logic [7:0]  b;
        logic [7:0]  tails[5];
        tails   = '{hsf_pkg::ChSpace, hsf_pkg::ChSpace, hsf_pkg::ChTab, hsf_pkg::ChLf,
                    hsf_pkg::ChCr};
        len     = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 16);
        noisy   = ($urandom_range(0, 9) == 0);
        ws_tail = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if (noisy) begin
                b = 8'($urandom_range(0, 255));
            end else if (ws_tail && (i + 2 >= len) && (len > 2)) begin
                b = tails[$urandom_range(0, 4)];
            end else begin
                b = pick_heading_byte();
            end
            push_byte(b, i == len - 1);
        end
    endtask

    initial begin
        int unsigned phase_goal;
        logic [7:0]  next_sep;
        slug_sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed headings with the reset separator. Leading digit and space are
        // dropped, punctuation inside a run does not split it, passers follow a
        // letter, a trailing tab becomes a final separator, trailing spaces give a
        // bare end marker, a heading of one non-ASCII byte gives an empty slug, and
        // CR plus LF between letters collapse into one separator.
        push_text("1 Ab ! C");
        push_text("z_-.9\t");
        push_byte(8'h00, 1'b0);
        push_byte("Q", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(hsf_pkg::ChSpace, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text("Z\r\ny");
        drain_slug();

        // Random phases, each under its own separator; the first two use the extremes.
        for (int p = 0; p < NumPhases; p++) begin
            if (p == 0) begin
                next_sep = 8'h00;
            end else if (p == 1) begin
                next_sep = 8'hFF;
            end else begin
                next_sep = 8'($urandom_range(0, 255));
            end
            write_separator(next_sep);
            phase_goal = bytes_sent + RandomBytes / NumPhases;
            while (bytes_sent < phase_goal) begin
                push_random_heading();
            end
            drain_slug();
        end

        if (slug_sb.mismatches == 0 && slug_sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/hsf_pkg.sv
sv/hsf_front.sv
sv/hsf_queue.sv
sv/hsf_back.sv
sv/heading_slug_filter.sv
dv/testbench.sv
